// File: hw/rtl/length_prefixed_record_deframer_core_macros.svh
// Assertion macros shared by the record deframer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef LENGTH_PREFIXED_RECORD_DEFRAMER_CORE_MACROS_SVH
`define LENGTH_PREFIXED_RECORD_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/lprd_pkg.sv
// Types and fixed constants of the length-prefixed record deframer.
// Depends on nothing; used by the channel interfaces and the core.
`default_nettype none

package lprd_pkg;

   typedef logic [2:0] kind_type;
   typedef logic [7:0] byte_type;
   typedef logic [3:0] phase_type;
   typedef logic [1:0] csr_index_type;

   // Result kinds.
   localparam kind_type KIND_NAME_BYTE   = 3'd0;
   localparam kind_type KIND_DATA_BYTE   = 3'd1;
   localparam kind_type KIND_NAME_DONE   = 3'd2;
   localparam kind_type KIND_RECORD_DONE = 3'd3;
   localparam kind_type KIND_TRUNCATED   = 3'd4;

   // Parser phases.
   localparam phase_type PH_HDR     = 4'd0;
   localparam phase_type PH_RLEN    = 4'd1;
   localparam phase_type PH_ID      = 4'd2;
   localparam phase_type PH_NLEN    = 4'd3;
   localparam phase_type PH_NAME    = 4'd4;
   localparam phase_type PH_NAMEZ   = 4'd5;
   localparam phase_type PH_NAMEOPT = 4'd6;
   localparam phase_type PH_DIR     = 4'd7;
   localparam phase_type PH_DLEN    = 4'd8;
   localparam phase_type PH_DATA    = 4'd9;
   localparam phase_type PH_DATAZ   = 4'd10;
   localparam phase_type PH_DATAOPT = 4'd11;

   // Register indexes of the configuration port.
   localparam csr_index_type CSR_HEADER_LENGTH     = 2'd0;
   localparam csr_index_type CSR_NAME_LENGTH_LIMIT = 2'd1;
   localparam csr_index_type CSR_DATA_LENGTH_LIMIT = 2'd2;

   // Fixed field sizes of a record, in bytes.
   localparam int unsigned LEN_BYTES = 4;
   localparam int unsigned ID_BYTES  = 5;
   localparam int unsigned DIR_BYTES = 41;

   // Register reset values.
   localparam logic [15:0] HEADER_LENGTH_RESET     = 16'd140;
   localparam logic [24:0] NAME_LENGTH_LIMIT_RESET = 25'h001_0000;
   localparam logic [31:0] DATA_LENGTH_LIMIT_RESET = 32'h0100_0000;

endpackage

`default_nettype wire

// File: hw/rtl/lprd_if.sv
// Valid/ready channel interfaces for the input bytes and the result words.
// Depends on lprd_pkg for the payload types.
`default_nettype none

interface lprd_req_if;
   logic               valid;
   logic               ready;
   lprd_pkg::byte_type byte_value;
   logic               end_of_input;

   modport source (output valid, output byte_value, output end_of_input, input ready);
   modport sink (input valid, input byte_value, input end_of_input, output ready);
endinterface

interface lprd_rsp_if;
   logic               valid;
   logic               ready;
   lprd_pkg::kind_type kind;
   lprd_pkg::byte_type payload;
   logic [15:0]        record_number;
   logic               last_of_run;

   modport source (output valid, output kind, output payload, output record_number,
                   output last_of_run, input ready);
   modport sink (input valid, input kind, input payload, input record_number,
                 input last_of_run, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/length_prefixed_record_deframer_core.sv
// A byte accepted into the input register is parsed into the result buffer, which then
// offers its first result word. One byte per cycle while the output is ready; a byte
// that yields two or three result words holds the input register while the buffer drains.
// The parse state updates once per byte in a single combinational pass.
// Reset is synchronous, active high; it restores all but the held byte and result words.
// Depends on lprd_pkg, lprd_if and the assertion macro header.
`default_nettype none

`include "length_prefixed_record_deframer_core_macros.svh"

module length_prefixed_record_deframer_core #(
   parameter int RECORD_INDEX_WIDTH = 16,
   parameter int LENGTH_WIDTH       = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   lprd_req_if.sink                     req_ch,
   lprd_rsp_if.source                   rsp_ch,
   input  wire                          csr_write_enable,
   input  wire lprd_pkg::csr_index_type csr_index,
   input  wire [31:0]                   csr_write_data
);

   // Configuration registers.
   logic [15:0] hdr_len_ff;
   logic [24:0] name_lim_ff;
   logic [31:0] data_lim_ff;

   // Input register.
   logic               in_valid_ff, in_valid_in;
   lprd_pkg::byte_type in_byte_ff;
   logic               in_eof_ff;

   // Parse state.
   lprd_pkg::phase_type           phase_ff, phase_in;
   logic [LENGTH_WIDTH-1:0]       pos_ff, pos_in;
   logic [LENGTH_WIDTH-1:0]       acc_ff, acc_in;
   logic [RECORD_INDEX_WIDTH-1:0] rec_ff, rec_in;

   // Result buffer: up to three words for one byte.
   lprd_pkg::kind_type kind_ff [0:2];
   lprd_pkg::byte_type pay_ff;
   logic [15:0]        rnum_ff;
   logic [1:0]         cnt_ff, cnt_in;
   logic [1:0]         idx_ff, idx_in;

   // Combinational pass signals.
   lprd_pkg::phase_type     eff_phase;
   logic [LENGTH_WIDTH-1:0] eff_pos;
   logic [LENGTH_WIDTH-1:0] pos_inc;
   logic                    skip;
   logic [31:0]             lim;
   lprd_pkg::kind_type      m0_kind, m1_kind;
   logic [1:0]              n_main;
   lprd_pkg::byte_type      e_pay;
   logic                    trunc;
   logic                    between;
   logic [1:0]              n_tot;
   lprd_pkg::kind_type      k0, k1;

   logic in_fire, rsp_fire, rsp_valid, process;
   lprd_pkg::kind_type rsp_kind;

   assign in_fire   = req_ch.valid && req_ch.ready;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_fire  = rsp_valid && rsp_ch.ready;
   // A held byte is parsed once the buffer is empty or its last word leaves now.
   assign process   = in_valid_ff && ((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_fire));
   assign req_ch.ready = !in_valid_ff || process;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_len_ff  <= lprd_pkg::HEADER_LENGTH_RESET;
         name_lim_ff <= lprd_pkg::NAME_LENGTH_LIMIT_RESET;
         data_lim_ff <= lprd_pkg::DATA_LENGTH_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            lprd_pkg::CSR_HEADER_LENGTH:     hdr_len_ff  <= csr_write_data[15:0];
            lprd_pkg::CSR_NAME_LENGTH_LIMIT: name_lim_ff <= csr_write_data[24:0];
            lprd_pkg::CSR_DATA_LENGTH_LIMIT: data_lim_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Input register holds one byte until it is parsed.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_fire) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         in_byte_ff <= req_ch.byte_value;
         in_eof_ff  <= req_ch.end_of_input;
      end
   end

   // Parse pass: resolve phases that hand the byte on, then handle the byte.
   always_comb begin
      eff_phase = phase_ff;
      eff_pos   = pos_ff;
      skip      = 1'b0;
      case (phase_ff)
         lprd_pkg::PH_HDR: begin
            if (pos_ff >= LENGTH_WIDTH'(hdr_len_ff)) begin
               eff_phase = lprd_pkg::PH_RLEN;
               eff_pos   = '0;
            end
         end
         lprd_pkg::PH_NAMEOPT: begin
            eff_phase = lprd_pkg::PH_DIR;
            eff_pos   = '0;
            skip      = (in_byte_ff == 8'd0);
         end
         lprd_pkg::PH_DATAOPT: begin
            eff_phase = lprd_pkg::PH_RLEN;
            eff_pos   = '0;
            skip      = (in_byte_ff == 8'd0);
         end
         lprd_pkg::PH_RLEN, lprd_pkg::PH_ID, lprd_pkg::PH_NLEN, lprd_pkg::PH_NAME,
         lprd_pkg::PH_NAMEZ, lprd_pkg::PH_DIR, lprd_pkg::PH_DLEN, lprd_pkg::PH_DATA,
         lprd_pkg::PH_DATAZ: ;
         default: begin
            // Unused codes start a record.
            eff_phase = lprd_pkg::PH_RLEN;
            eff_pos   = '0;
         end
      endcase

      pos_inc  = eff_pos + LENGTH_WIDTH'(1);
      phase_in = eff_phase;
      pos_in   = eff_pos;
      acc_in   = acc_ff;
      rec_in   = rec_ff;
      m0_kind  = lprd_pkg::KIND_NAME_BYTE;
      m1_kind  = lprd_pkg::KIND_NAME_BYTE;
      n_main   = 2'd0;
      e_pay    = 8'd0;
      lim      = (eff_phase == lprd_pkg::PH_NLEN) ? 32'(name_lim_ff) : data_lim_ff;

      if (!skip) begin
         case (eff_phase)
            lprd_pkg::PH_HDR: begin
               pos_in = pos_inc;
            end
            lprd_pkg::PH_RLEN: begin
               pos_in = pos_inc;
               if (pos_inc >= LENGTH_WIDTH'(lprd_pkg::LEN_BYTES)) begin
                  phase_in = lprd_pkg::PH_ID;
                  pos_in   = '0;
               end
            end
            lprd_pkg::PH_ID: begin
               pos_in = pos_inc;
               if (pos_inc >= LENGTH_WIDTH'(lprd_pkg::ID_BYTES)) begin
                  phase_in = lprd_pkg::PH_NLEN;
                  pos_in   = '0;
                  acc_in   = '0;
               end
            end
            lprd_pkg::PH_NLEN, lprd_pkg::PH_DLEN: begin
               // Little-endian assembly, one byte lane per position.
               acc_in = acc_ff | LENGTH_WIDTH'(32'(in_byte_ff) << {eff_pos[1:0], 3'b000});
               pos_in = pos_inc;
               if (pos_inc >= LENGTH_WIDTH'(lprd_pkg::LEN_BYTES)) begin
                  pos_in = '0;
                  if ((acc_in != '0) && (32'(acc_in) < lim)) begin
                     phase_in = (eff_phase == lprd_pkg::PH_NLEN) ?
                                lprd_pkg::PH_NAME : lprd_pkg::PH_DATA;
                  end else begin
                     phase_in = (eff_phase == lprd_pkg::PH_NLEN) ?
                                lprd_pkg::PH_NAMEZ : lprd_pkg::PH_DATAZ;
                  end
               end
            end
            lprd_pkg::PH_NAME: begin
               m0_kind = lprd_pkg::KIND_NAME_BYTE;
               e_pay   = in_byte_ff;
               n_main  = 2'd1;
               pos_in  = pos_inc;
               if (pos_inc >= acc_ff) begin
                  m1_kind  = lprd_pkg::KIND_NAME_DONE;
                  n_main   = 2'd2;
                  phase_in = lprd_pkg::PH_NAMEOPT;
                  pos_in   = '0;
               end
            end
            lprd_pkg::PH_NAMEZ: begin
               n_main = 2'd1;
               if (in_byte_ff == 8'd0) begin
                  m0_kind  = lprd_pkg::KIND_NAME_DONE;
                  phase_in = lprd_pkg::PH_DIR;
                  pos_in   = '0;
               end else begin
                  m0_kind = lprd_pkg::KIND_NAME_BYTE;
                  e_pay   = in_byte_ff;
               end
            end
            lprd_pkg::PH_DIR: begin
               pos_in = pos_inc;
               if (pos_inc >= LENGTH_WIDTH'(lprd_pkg::DIR_BYTES)) begin
                  phase_in = lprd_pkg::PH_DLEN;
                  pos_in   = '0;
                  acc_in   = '0;
               end
            end
            lprd_pkg::PH_DATA: begin
               m0_kind = lprd_pkg::KIND_DATA_BYTE;
               e_pay   = in_byte_ff;
               n_main  = 2'd1;
               pos_in  = pos_inc;
               if (pos_inc >= acc_ff) begin
                  m1_kind  = lprd_pkg::KIND_RECORD_DONE;
                  n_main   = 2'd2;
                  rec_in   = rec_ff + RECORD_INDEX_WIDTH'(1);
                  phase_in = lprd_pkg::PH_DATAOPT;
                  pos_in   = '0;
               end
            end
            lprd_pkg::PH_DATAZ: begin
               if (in_byte_ff == 8'd0) begin
                  m0_kind  = lprd_pkg::KIND_RECORD_DONE;
                  n_main   = 2'd1;
                  rec_in   = rec_ff + RECORD_INDEX_WIDTH'(1);
                  phase_in = lprd_pkg::PH_RLEN;
                  pos_in   = '0;
               end else begin
                  m0_kind = lprd_pkg::KIND_DATA_BYTE;
                  e_pay   = in_byte_ff;
                  n_main  = 2'd1;
                  if (in_eof_ff) begin
                     // End of file closes an unterminated data field.
                     m1_kind  = lprd_pkg::KIND_RECORD_DONE;
                     n_main   = 2'd2;
                     rec_in   = rec_ff + RECORD_INDEX_WIDTH'(1);
                     phase_in = lprd_pkg::PH_RLEN;
                     pos_in   = '0;
                  end
               end
            end
            default: begin
               phase_in = lprd_pkg::PH_RLEN;
               pos_in   = '0;
            end
         endcase
      end

      // End of file: mark truncation inside a record, then start a new file.
      between = (phase_in inside {lprd_pkg::PH_HDR, lprd_pkg::PH_DATAOPT}) ||
                ((phase_in == lprd_pkg::PH_RLEN) && (pos_in == '0));
      trunc = in_eof_ff && !between;
      if (in_eof_ff) begin
         phase_in = lprd_pkg::PH_HDR;
         pos_in   = '0;
         acc_in   = '0;
         rec_in   = '0;
      end

      n_tot = n_main + {1'b0, trunc};
      k0    = (n_main == 2'd0) ? lprd_pkg::KIND_TRUNCATED : m0_kind;
      k1    = (n_main == 2'd1) ? lprd_pkg::KIND_TRUNCATED : m1_kind;
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lprd_pkg::PH_HDR;
         pos_ff   <= '0;
         acc_ff   <= '0;
         rec_ff   <= '0;
      end else if (process) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         acc_ff   <= acc_in;
         rec_ff   <= rec_in;
      end
   end

   // Result buffer count and read index.
   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (process) begin
         cnt_in = n_tot;
         idx_in = 2'd0;
      end else if (rsp_fire) begin
         cnt_in = cnt_ff - 2'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         idx_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         kind_ff[0] <= k0;
         kind_ff[1] <= k1;
         kind_ff[2] <= lprd_pkg::KIND_TRUNCATED;
         pay_ff     <= e_pay;
         rnum_ff    <= 16'(32'(rec_ff));
      end
   end

   // Result word selection.
   always_comb begin
      case (idx_ff)
         2'd0:    rsp_kind = kind_ff[0];
         2'd1:    rsp_kind = kind_ff[1];
         default: rsp_kind = kind_ff[2];
      endcase
   end

   assign rsp_ch.valid         = rsp_valid;
   assign rsp_ch.kind          = rsp_kind;
   assign rsp_ch.payload       = (idx_ff == 2'd0) ? pay_ff : 8'd0;
   assign rsp_ch.record_number = rnum_ff;
   assign rsp_ch.last_of_run   = (cnt_ff == 2'd1);

   // Checks on the parser and the result buffer.
   `LPRD_ASSERT_NEXT(a_eof_restarts_file, clock, reset, process && in_eof_ff,
      (phase_ff == lprd_pkg::PH_HDR) && (rec_ff == '0), "end of file did not restart parser")
   `LPRD_ASSERT_NEXT(a_record_count_steps, clock, reset, 1'b1,
      (rec_ff == $past(rec_ff)) || (rec_ff == $past(rec_ff) + 1'b1) || (rec_ff == '0),
      "record counter moved by more than one")
   `LPRD_ASSERT_NEXT(a_held_byte_stable, clock, reset, in_valid_ff && !process,
      $stable(in_byte_ff) && $stable(in_eof_ff), "held input byte was overwritten")
   `LPRD_ASSERT_NOW(a_buffer_in_range, clock, reset, cnt_ff != 2'd0,
      ({1'b0, idx_ff} + {1'b0, cnt_ff}) <= 3'd3, "result buffer read past its slots")

endmodule

`default_nettype wire
